// File: sv/mbd_pkg.sv
// Package with shared types and constants for the multi-button debouncer.
package mbd_pkg;

    // Fixed field widths
    localparam int PIN_W    = 8;
    localparam int CNT8_W   = 8;
    localparam int BTN_W    = 3;
    localparam int WAIT_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVELS = 2'd1;

    // Reset values and limits
    localparam logic [CNT8_W-1:0] STABLE_TICKS_RST  = 8'd4;
    localparam logic [PIN_W-1:0]  ACTIVE_LEVELS_RST = 8'd0;
    localparam logic [CNT8_W-1:0] COUNT_MAX         = 8'd255;

    // One result item
    typedef struct packed {
        logic              ev_valid;
        logic [BTN_W-1:0]  button;
        logic [WAIT_W-1:0] count;
    } t_result;

endpackage

// File: sv/mbd_lane.sv
// One button lane: saturating stability counter and event detection.
module mbd_lane
    import mbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic              i_pin,
    input  logic              i_active,
    input  logic [CNT8_W-1:0] i_stable_ticks,
    output logic              o_fire
);

    logic [CNT8_W-1:0] r_cnt;
    logic [CNT8_W-1:0] n_cnt;
    logic              match;

    assign match  = (i_pin == i_active);

    // Fire when the count before this sample equals the stable count
    assign o_fire = i_tick && match && (r_cnt == i_stable_ticks);

    // Bump with saturation on a match, clear on a mismatch
    always_comb begin
        n_cnt = r_cnt;
        if (i_tick) begin
            if (!match) begin
                n_cnt = '0;
            end else if (r_cnt != COUNT_MAX) begin
                n_cnt = r_cnt + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: sv/mbd_event_fifo.sv
// Merge stage: queues lane events into a banked ring and serves pops.
module mbd_event_fifo
    import mbd_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int FIFO_DEPTH  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_req,
    input  logic [NUM_BUTTONS-1:0] i_fire,
    input  logic                   i_out_stall,
    output logic                   o_ready,
    output logic                   o_out_valid,
    output t_result                o_result
);

    localparam int NB_P2    = 1 << $clog2(NUM_BUTTONS);
    localparam int BANKS    = (NB_P2 < 2) ? 2 : NB_P2;
    localparam int BANK_W   = $clog2(BANKS);
    localparam int DEPTH_P2 = 1 << $clog2(FIFO_DEPTH);
    localparam int PHYS     = (DEPTH_P2 > 2 * BANKS) ? DEPTH_P2 : 2 * BANKS;
    localparam int PA_W     = $clog2(PHYS);
    localparam int ROW_W    = PA_W - BANK_W;
    localparam int ROWS     = PHYS / BANKS;
    localparam int CNT_W    = $clog2(FIFO_DEPTH);
    localparam int PC_W     = $clog2(NUM_BUTTONS + 1);
    localparam int CW       = ((PC_W > CNT_W) ? PC_W : CNT_W) + 1;

    // Storage, banked so that one tick writes each bank at most once
    logic [BTN_W-1:0] mem [BANKS][ROWS];
    logic [BTN_W-1:0] r_rd_q [BANKS];

    logic [PA_W-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid;
    logic              r_ev_valid;
    logic [BANK_W-1:0] r_sel;
    logic [CNT_W-1:0]  r_wait;

    logic [PC_W-1:0]   pre [NUM_BUTTONS];
    logic [PC_W-1:0]   total;
    logic [CNT_W-1:0]  free_slots;
    logic [CW-1:0]     take;
    logic [NUM_BUTTONS-1:0] acc;
    logic [PA_W-1:0]   slot [NUM_BUTTONS];
    logic [BANKS-1:0]  bank_we;
    logic [ROW_W-1:0]  bank_row  [BANKS];
    logic [BTN_W-1:0]  bank_data [BANKS];
    logic              is_tick, is_pop, pop_ok;

    assign o_ready = !r_out_valid || !i_out_stall;
    assign is_tick = i_adv && (i_req == REQ_TICK);
    assign is_pop  = i_adv && (i_req == REQ_POP);
    assign pop_ok  = is_pop && (r_count != '0);

    // Rank each firing lane and keep those that fit
    always_comb begin
        pre[0] = '0;
        for (int i = 1; i < NUM_BUTTONS; i++) begin
            pre[i] = pre[i-1] + PC_W'(i_fire[i-1]);
        end
        total      = pre[NUM_BUTTONS-1] + PC_W'(i_fire[NUM_BUTTONS-1]);
        free_slots = CNT_W'(FIFO_DEPTH - 1) - r_count;
        take       = (CW'(total) < CW'(free_slots)) ? CW'(total) : CW'(free_slots);
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            acc[i]  = i_fire[i] && (CW'(pre[i]) < CW'(free_slots));
            slot[i] = r_wr + PA_W'(pre[i]);
        end
    end

    // Steer each kept event to the bank of its slot
    always_comb begin
        for (int b = 0; b < BANKS; b++) begin
            bank_we[b]   = 1'b0;
            bank_row[b]  = '0;
            bank_data[b] = '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (is_tick && acc[i] && (slot[i][BANK_W-1:0] == BANK_W'(b))) begin
                    bank_we[b]   = 1'b1;
                    bank_row[b]  = slot[i][PA_W-1:BANK_W];
                    bank_data[b] = BTN_W'(i);
                end
            end
        end
    end

    // Advance pointers and count
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (is_tick) begin
            n_wr    = r_wr + PA_W'(take);
            n_count = r_count + CNT_W'(take);
        end else if (pop_ok) begin
            n_rd    = r_rd + PA_W'(1);
            n_count = r_count - CNT_W'(1);
        end
    end

    // Write kept events, read every bank at the head row on a pop
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < BANKS; b++) begin
            if (bank_we[b]) begin
                mem[b][bank_row[b]] <= bank_data[b];
            end
            if (pop_ok) begin
                r_rd_q[b] <= mem[b][r_rd[PA_W-1:BANK_W]];
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
            if (i_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register, held until the transfer
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ev_valid <= pop_ok;
            r_sel      <= r_rd[BANK_W-1:0];
            r_wait     <= n_count;
        end
    end

    logic [CNT_W+WAIT_W-1:0] wait_ext;
    assign wait_ext = {{WAIT_W{1'b0}}, r_wait};

    assign o_out_valid     = r_out_valid;
    assign o_result.ev_valid = r_ev_valid;
    assign o_result.button = r_ev_valid ? r_rd_q[r_sel] : '0;
    assign o_result.count  = wait_ext[WAIT_W-1:0];

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH - 1))
        else $error("event count above capacity");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PA_W'(r_wr - r_rd) == PA_W'(r_count))
        else $error("pointer gap disagrees with event count");

    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev_valid) |-> (r_wait < CNT_W'(FIFO_DEPTH - 1)))
        else $error("popped result reports a full queue");
`endif

endmodule

// File: sv/multi_button_debounce_event_fifo.sv
// Top level: configuration, button lanes, lane stage and event queue.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_stall| i_req_type, i_pin_levels
//  out     | output    | o_out_valid/ i_out_stall| o_event_valid, o_event_button,
//          |           |                        | o_waiting_count
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle unless o_in_stall holds it; its result passes the lane stage
// register, then the queue's result register, before it is offered.
// Reset (synchronous, active low) clears counters, pointers and valid flags and loads
// the configuration reset values; queue contents are not cleared and need no clearing pass.
// A stalled result holds the pipeline; input stalls only when both stages are full
// and the result is stalled.
module multi_button_debounce_event_fifo
    import mbd_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int FIFO_DEPTH  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [PIN_W-1:0]     i_pin_levels,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_event_valid,
    output logic [BTN_W-1:0]     o_event_button,
    output logic [WAIT_W-1:0]    o_waiting_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT8_W-1:0]    i_cfg_data
);

    logic [CNT8_W-1:0]      r_stable_ticks;
    logic [PIN_W-1:0]       r_active_levels;
    logic                   r_s1_valid;
    logic                   r_s1_req;
    logic [NUM_BUTTONS-1:0] r_s1_fire;
    logic [NUM_BUTTONS-1:0] fire;
    logic                   in_xfer, tick_xfer, s1_adv, q_ready;
    t_result                result;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_ticks  <= STABLE_TICKS_RST;
            r_active_levels <= ACTIVE_LEVELS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STABLE_TICKS:  r_stable_ticks  <= i_cfg_data;
                CFG_ACTIVE_LEVELS: r_active_levels <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input handshake
    assign s1_adv     = r_s1_valid && q_ready;
    assign o_in_stall = r_s1_valid && !q_ready;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign tick_xfer  = in_xfer && (i_req_type == REQ_TICK);

    // Button lanes; buttons past the pin field see level 0 on both sides
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic pin, act;
        if (g < PIN_W) begin : g_pin
            assign pin = i_pin_levels[g];
            assign act = r_active_levels[g];
        end else begin : g_zero
            assign pin = 1'b0;
            assign act = 1'b0;
        end
        mbd_lane u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_tick         (tick_xfer),
            .i_pin          (pin),
            .i_active       (act),
            .i_stable_ticks (r_stable_ticks),
            .o_fire         (fire[g])
        );
    end

    // Lane stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_req  <= i_req_type;
            r_s1_fire <= fire;
        end
    end

    // Event queue and result register
    mbd_event_fifo #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .FIFO_DEPTH  (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (s1_adv),
        .i_req       (r_s1_req),
        .i_fire      (r_s1_fire),
        .i_out_stall (i_out_stall),
        .o_ready     (q_ready),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_event_valid   = result.ev_valid;
    assign o_event_button  = result.button;
    assign o_waiting_count = result.count;

endmodule

// File: verif/tb.sv
// Testbench for multi_button_debounce_event_fifo: directed and random traffic against a debounce predictor.
`timescale 1ns / 1ps

module tb;
    import mbd_pkg::*;

    localparam int NB = 8;
    localparam int QD = 16;

    // Clock, reset and block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_req_type = REQ_TICK;
    logic [PIN_W-1:0]     i_pin_levels = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_event_valid;
    logic [BTN_W-1:0]     o_event_button;
    logic [WAIT_W-1:0]    o_waiting_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_STABLE_TICKS;
    logic [CNT8_W-1:0]    i_cfg_data = '0;

    // Predicted debounce state and settings
    logic [CNT8_W-1:0] btn_count [NB];
    logic [BTN_W-1:0]  evq_store [QD];
    logic [WAIT_W-1:0] evq_rd;
    logic [WAIT_W-1:0] evq_wr;
    logic [CNT8_W-1:0] cfg_stable;
    logic [PIN_W-1:0]  cfg_active;

    // Expected results in transfer order
    t_result pending_results [$];

    int n_errors = 0;
    int n_sent = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold = 0;
    int run_left = 0;
    logic run_stall = 1'b0;

    multi_button_debounce_event_fifo DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_pin_levels    (i_pin_levels),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_valid   (o_event_valid),
        .o_event_button  (o_event_button),
        .o_waiting_count (o_waiting_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Advance the predicted state by one item and return its result
    function automatic t_result debounce_predict(logic req, logic [PIN_W-1:0] pins);
        t_result r;
        logic [WAIT_W-1:0] wr_next;
        r = '0;
        if (req == REQ_TICK) begin
            for (int b = 0; b < NB; b++) begin
                if (pins[b] == cfg_active[b]) begin
                    if (btn_count[b] == cfg_stable) begin
                        // drop the event while the ring is full
                        wr_next = evq_wr + 1'b1;
                        if (wr_next != evq_rd) begin
                            evq_store[evq_wr] = BTN_W'(b);
                            evq_wr = wr_next;
                        end
                    end
                    if (btn_count[b] != COUNT_MAX)
                        btn_count[b] = btn_count[b] + 1'b1;
                end else begin
                    btn_count[b] = '0;
                end
            end
        end else if (evq_rd != evq_wr) begin
            r.ev_valid = 1'b1;
            r.button   = evq_store[evq_rd];
            evq_rd     = evq_rd + 1'b1;
        end
        r.count = evq_wr - evq_rd;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item, hold it until the transfer, then predict its result
    task automatic send_item(input logic req, input logic [PIN_W-1:0] pins);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_pin_levels <= pins;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(debounce_predict(req, pins));
        n_sent++;
    endtask

    // Stop sending and wait until every expected result has arrived
    task automatic settle_queue();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_config(input logic [CNT8_W-1:0] stable, input logic [PIN_W-1:0] active);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_STABLE_TICKS;
        i_cfg_data  <= stable;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_stable = stable;
        i_cfg_index <= CFG_ACTIVE_LEVELS;
        i_cfg_data  <= active;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_active = active;
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: check each transfer, then choose the next stall
    always @(posedge i_clk) begin : result_sink
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_event_valid, o_event_button, o_waiting_count};
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: result with nothing expected: valid=%0b button=%0d count=%0d",
                         $time, got.ev_valid, got.button, got.count);
            end else begin
                want = pending_results.pop_front();
                if (got.ev_valid !== want.ev_valid) begin
                    n_errors++;
                    $display("%0t: event_valid expected %0b got %0b",
                             $time, want.ev_valid, got.ev_valid);
                end
                if (got.button !== want.button) begin
                    n_errors++;
                    $display("%0t: event_button expected %0d got %0d",
                             $time, want.button, got.button);
                end
                if (got.count !== want.count) begin
                    n_errors++;
                    $display("%0t: waiting_count expected %0d got %0d",
                             $time, want.count, got.count);
                end
            end
        end
        if (rx_hold > 0) begin
            i_out_stall <= 1'b1;
            rx_hold <= rx_hold - 1;
        end else if (rx_steady) begin
            i_out_stall <= 1'b0;
        end else begin
            if (run_left == 0) begin
                run_stall = ($urandom_range(0, 99) < 40);
                run_left  = run_stall ? (pick_gap() + 1) : $urandom_range(1, 10);
            end
            run_left--;
            i_out_stall <= run_stall;
        end
    end

    // Extremes of pins, pop on empty, reset settings, zero stable count, full ring
    task automatic test_directed();
        send_item(REQ_POP, 8'h00);
        repeat (5) send_item(REQ_TICK, 8'h00);
        repeat (2) send_item(REQ_POP, 8'hFF);
        send_item(REQ_TICK, 8'hFF);
        settle_queue();
        set_config(8'd0, 8'hA5);
        send_item(REQ_TICK, 8'hA5);
        send_item(REQ_TICK, 8'h5A);
        send_item(REQ_TICK, 8'hA5);
        repeat (16) send_item(REQ_POP, 8'h00);
        settle_queue();
    endtask

    // Stable count at its maximum: a held button repeats its event every tick
    task automatic test_repeat_at_max();
        logic [PIN_W-1:0] active;
        logic [PIN_W-1:0] pat;
        active = 8'($urandom);
        pat    = active ^ 8'h3C;
        set_config(COUNT_MAX, active);
        repeat (255) send_item(REQ_TICK, pat);
        repeat (30) begin
            send_item(REQ_TICK, pat);
            if ($urandom_range(0, 1))
                send_item(REQ_POP, 8'($urandom));
        end
        repeat (20) send_item(REQ_POP, 8'($urandom));
        settle_queue();
    endtask

    // Hold the result side for a long stretch while items keep coming
    task automatic test_backpressure();
        set_config(8'd1, 8'($urandom));
        tx_steady = 1'b1;
        rx_hold = 300;
        repeat (40) send_item(1'($urandom), 8'($urandom));
        tx_steady = 1'b0;
        settle_queue();
    endtask

    // Phases of held patterns, noise and pop bursts under random settings
    task automatic test_random_traffic();
        int target;
        int pop_rate;
        int kind;
        int len;
        logic [PIN_W-1:0] pat;
        logic [CNT8_W-1:0] stable;
        logic [PIN_W-1:0] active;
        for (int ph = 0; ph < 16; ph++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
                stable = 8'($urandom_range(0, 5));
            else if (kind < 8)
                stable = 8'($urandom_range(6, 20));
            else
                stable = 8'($urandom);
            active = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom);
            set_config(stable, active);
            tx_steady = (ph % 4 == 3);
            rx_steady = (ph % 4 == 3);
            pop_rate  = $urandom_range(10, 60);
            target    = n_sent + 100;
            while (n_sent < target) begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    // hold one pattern near the active levels
                    pat = $urandom_range(0, 1) ? 8'h00 : 8'($urandom) & 8'($urandom);
                    pat = pat ^ cfg_active;
                    len = $urandom_range(1, ((cfg_stable > 10) ? 10 : cfg_stable) + 3);
                    repeat (len) begin
                        send_item(REQ_TICK, pat);
                        if ($urandom_range(0, 99) < pop_rate)
                            send_item(REQ_POP, 8'($urandom));
                    end
                end else if (kind < 85) begin
                    send_item(REQ_TICK, 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 6)) send_item(REQ_POP, 8'($urandom));
                end
            end
            settle_queue();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        for (int b = 0; b < NB; b++)
            btn_count[b] = '0;
        for (int e = 0; e < QD; e++)
            evq_store[e] = '0;
        evq_rd     = '0;
        evq_wr     = '0;
        cfg_stable = STABLE_TICKS_RST;
        cfg_active = ACTIVE_LEVELS_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_repeat_at_max();
        test_backpressure();
        test_random_traffic();

        settle_queue();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: multi_button_debounce_event_fifo.f
sv/mbd_pkg.sv
sv/mbd_lane.sv
sv/mbd_event_fifo.sv
sv/multi_button_debounce_event_fifo.sv
verif/tb.sv
